### rtl/lfte_pkg.sv
`timescale 1ns / 1ps
package lfte_pkg;

  localparam int MAX_WIDTH_DEF = 32;

  // positions are carried at this width so that a tab stop past the line still fits
  localparam int POS_W = 8;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_BLANK = 8'd32;

  localparam logic [5:0] WIDTH_RESET = 6'd10;
  localparam logic [2:0] TAB_RESET   = 3'd2;
  localparam logic [5:0] WIDTH_MIN   = 6'd2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAB_SHIFT  = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_NL
  } state_t;

  typedef struct packed {
    logic             shift;
    logic             wr;
    logic [7:0]       wchar;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
  } cell_cmd_t;

endpackage

### rtl/lfte_cell.sv
`timescale 1ns / 1ps
module lfte_cell
  import lfte_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  cell_cmd_t  cmd,
  input  logic [7:0] right,
  output logic [7:0] data
);

  localparam logic [POS_W-1:0] POS = POS_W'(IDX);

  logic hit;

  assign hit = cmd.wr && (POS >= cmd.lo) && (POS < cmd.hi);

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      data <= right;
    end else if (hit) begin
      data <= cmd.wchar;
    end
  end

endmodule

### rtl/lfte_ctrl.sv
`timescale 1ns / 1ps
module lfte_ctrl
  import lfte_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_char,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_char,
  output logic                  out_last,
  input  logic [7:0]            head,
  output cell_cmd_t             cmd
);

  localparam int FW = $clog2(MAX_WIDTH + 1);
  localparam logic [5:0] WMAX = 6'(MAX_WIDTH);

  state_t         state, state_next;
  logic [5:0]     line_width;
  logic [2:0]     tab_shift;
  logic [FW-1:0]  fill, lb, cnt;
  logic [POS_W-1:0] fill_next, lb_next, cnt_next;

  logic [5:0]       w_cl;
  logic [POS_W-1:0] w8, fill8, lb8, mask8, stop8, tend8, fill1, lbp, cut8;
  logic             acc, fire, is_tab, is_nl, do_emit;

  always_comb begin
    if (line_width < WIDTH_MIN) begin
      w_cl = WIDTH_MIN;
    end else if (line_width > WMAX) begin
      w_cl = WMAX;
    end else begin
      w_cl = line_width;
    end
  end

  assign w8    = POS_W'(w_cl);
  assign fill8 = POS_W'(fill);
  assign lb8   = POS_W'(lb);
  assign mask8 = (POS_W'(1) << tab_shift) - POS_W'(1);
  // next tab stop strictly past the current column
  assign stop8 = (fill8 | mask8) + POS_W'(1);
  assign tend8 = (stop8 < w8) ? stop8 : w8;
  assign fill1 = fill8 + POS_W'(1);
  // a blank in column zero never counts as a fold point
  assign lbp   = (in_char == CH_BLANK && fill != '0) ? fill8 : lb8;
  assign cut8  = (lbp == '0) ? w8 : lbp + POS_W'(1);

  assign is_tab = (in_char == CH_TAB);
  assign is_nl  = (in_char == CH_NL);
  assign acc    = in_valid && (state == ST_IDLE);
  assign fire   = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // what an accepted byte leaves behind
  always_comb begin
    fill_next = fill8;
    lb_next   = lb8;
    cnt_next  = POS_W'(cnt);
    do_emit   = 1'b0;
    if (is_tab) begin
      if (tend8 == w8) begin
        do_emit   = 1'b1;
        cnt_next  = w8;
        fill_next = '0;
        lb_next   = '0;
      end else begin
        fill_next = tend8;
        lb_next   = tend8 - POS_W'(1);
      end
    end else if (is_nl) begin
      do_emit   = (fill != '0);
      cnt_next  = fill8;
      fill_next = '0;
      lb_next   = '0;
    end else if (fill1 == w8) begin
      do_emit   = 1'b1;
      cnt_next  = cut8;
      fill_next = w8 - cut8;
      lb_next   = '0;
    end else begin
      fill_next = fill1;
      lb_next   = lbp;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc && do_emit) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (fire && cnt == FW'(1)) begin
          state_next = ST_NL;
        end
      end
      ST_NL: begin
        if (fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.shift = (state == ST_EMIT) && fire;
    cmd.wr    = acc && !is_nl;
    cmd.wchar = is_tab ? CH_BLANK : in_char;
    cmd.lo    = fill8;
    cmd.hi    = is_tab ? tend8 : fill1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      line_width <= WIDTH_RESET;
      tab_shift  <= TAB_RESET;
      fill       <= '0;
      lb         <= '0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_LINE_WIDTH: begin
            line_width <= cfg_data;
            fill       <= '0;
            lb         <= '0;
          end
          REG_TAB_SHIFT: tab_shift <= cfg_data[2:0];
          default: ;
        endcase
      end else if (acc) begin
        fill <= fill_next[FW-1:0];
        lb   <= lb_next[FW-1:0];
        cnt  <= cnt_next[FW-1:0];
      end
      if ((state == ST_EMIT || state == ST_NL) && fire) begin
        out_valid <= 1'b1;
        if (state == ST_EMIT) begin
          cnt <= cnt - FW'(1);
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT || state == ST_NL) && fire) begin
      out_char <= (state == ST_EMIT) ? head : CH_NL;
      out_last <= (state == ST_NL);
    end
  end

endmodule

### rtl/line_fold_with_tab_expansion.sv
`timescale 1ns / 1ps
// channel  direction  handshake            payload
// cfg      in         cfg_write            cfg_index, cfg_data
// in       in         in_valid / in_stall  in_char
// out      out        out_valid / out_stall out_char, out_last
//
// a byte that does not close a line is written into the line store; a flushed line
// is shifted out of the first cell of the line store one byte per cycle while the
// output does not stall, newline last.
// reset (synchronous) empties the line and restores line_width 10, tab_shift 2.
// input stalls while a line is being shifted out; output stall holds the
// output register and the shift line.
module line_fold_with_tab_expansion
  import lfte_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_char,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_char,
  output logic                  out_last
);

  cell_cmd_t  cmd;
  logic [7:0] cells [MAX_WIDTH+1];

  // past the end of the line the shift line fills with zero
  assign cells[MAX_WIDTH] = 8'h00;

  lfte_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_char  (in_char),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char (out_char),
    .out_last (out_last),
    .head     (cells[0]),
    .cmd      (cmd)
  );

  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
    lfte_cell #(
      .IDX(i)
    ) u_cell (
      .clk  (clk),
      .cmd  (cmd),
      .right(cells[i+1]),
      .data (cells[i])
    );
  end

endmodule

### rtl/lfte_checker.sv
`timescale 1ns / 1ps
module lfte_checker
  import lfte_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       out_last
);

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("output changed while stalled");

  // a line ends with a newline
  a_last_nl: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_char == CH_NL)
    else $error("final byte is not a newline");

  // once a line starts it comes out without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("gap inside an emitted line");

  // no new byte taken in the middle of a line
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> in_stall)
    else $error("input open during a line");

endmodule

bind line_fold_with_tab_expansion lfte_checker u_lfte_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_char (out_char),
  .out_last (out_last)
);
